/* rtl/core/mva_pkg.sv */
`default_nettype none
package mva_pkg;
	localparam int MAX_CHIPS = 4;
	localparam int VOICES_PER_CHIP = 8;
	localparam int CHANNELS = 16;

	typedef enum logic [2:0] {
		OP_NOTE_ON = 3'd0,
		OP_NOTE_OFF = 3'd1,
		OP_ALL_OFF = 3'd2,
		OP_BEND = 3'd3,
		OP_PROGRAM = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		CMD_STOP = 2'd0,
		CMD_START = 2'd1,
		CMD_RETUNE = 2'd2
	} cmd_t;

	localparam logic CFG_ACTIVE_CHIPS = 1'b0;
	localparam logic CFG_BANK_READY = 1'b1;

	typedef enum logic [2:0] {
		K_OFF = 3'd0,
		K_ON = 3'd1,
		K_ALL = 3'd2,
		K_BEND = 3'd3,
		K_NONE = 3'd4,
		K_PROG = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic all;
		logic [3:0] channel;
		logic [6:0] note;
		logic [6:0] velocity;
		logic [13:0] bend;
		logic [6:0] program_value;
	} job_t;
endpackage
`default_nettype wire

/* rtl/core/mva_front.sv */
`default_nettype none
module mva_front (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_ready,
	input wire [2:0] operation,
	input wire [3:0] channel,
	input wire all_channels,
	input wire [6:0] note,
	input wire [6:0] velocity,
	input wire [13:0] bend,
	input wire [6:0] program_value,
	input wire bank_ready,
	output logic job_valid,
	input wire job_ready,
	output mva_pkg::job_t job
);
	import mva_pkg::*;
	job_t q_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	job_t cls;
	logic chan_ok, push, pop;

	assign chan_ok = ({1'b0, channel} < 5'(CHANNELS));
	always_comb begin
		cls = '{kind: K_NONE, all: all_channels, channel: channel, note: note,
			velocity: velocity, bend: bend, program_value: program_value};
		case (operation)
			OP_NOTE_ON: if (chan_ok && bank_ready) cls.kind = (velocity == 7'd0) ? K_OFF : K_ON;
			OP_NOTE_OFF: if (chan_ok) cls.kind = K_OFF;
			OP_ALL_OFF: cls.kind = K_ALL;
			OP_BEND: if (chan_ok) cls.kind = K_BEND;
			OP_PROGRAM: if (chan_ok) cls.kind = K_PROG;
			default: cls.kind = K_NONE;
		endcase
		if (!chan_ok && operation == OP_ALL_OFF && !all_channels) cls.kind = K_NONE;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign job_valid = (cnt_q != 2'd0);
	assign pop = job_valid && job_ready;
	assign job = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) q_q[wp_q] <= cls;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !in_ready) else $error("full queue accepts");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !job_valid) else $error("empty queue valid");
endmodule
`default_nettype wire

/* rtl/core/mva_back.sv */
`default_nettype none
module mva_back (
	input wire clk,
	input wire arst_n,
	input wire job_valid,
	output logic job_ready,
	input mva_pkg::job_t job,
	input wire [5:0] capacity,
	input wire clear,
	output logic out_valid,
	input wire out_ready,
	output logic [1:0] command,
	output logic [4:0] voice,
	output logic [3:0] out_channel,
	output logic [6:0] out_note,
	output logic [6:0] out_velocity,
	output logic [6:0] out_program,
	output logic [13:0] out_bend,
	output logic last
);
	import mva_pkg::*;
	localparam int SLOTS = MAX_CHIPS * VOICES_PER_CHIP;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_EMIT = 5'b00100,
		S_START = 5'b01000,
		S_WAIT = 5'b10000
	} state_t;

	state_t state_q;
	job_t job_q;
	logic [SLOTS-1:0] used_q;
	logic [3:0] sch_q [SLOTS];
	logic [6:0] snote_q [SLOTS];
	logic [31:0] sstamp_q [SLOTS];
	logic [31:0] age_q;
	logic [13:0] cbend_q [CHANNELS];
	logic [6:0] cprog_q [CHANNELS];
	logic [5:0] idx_q;
	logic found_q, free_q;
	logic [SW-1:0] best_q;
	logic [31:0] oldest_q;
	logic pend_q;
	logic [1:0] pcmd_q;
	logic [SW-1:0] pv_q;
	logic [3:0] pch_q;
	logic [13:0] pbend_q;
	logic [SW-1:0] iv;
	logic [3:0] cidx;
	logic hit, ob_free, at_end, xfer;

	assign iv = idx_q[SW-1:0];
	assign cidx = job_q.channel[$clog2(CHANNELS > 1 ? CHANNELS : 2)-1:0];
	assign at_end = (idx_q + 6'd1 >= capacity);
	assign ob_free = !out_valid || out_ready;
	assign job_ready = (state_q == S_IDLE);

	// A stop or retune found in a scan is held until the next match or the end of the scan
	// shows whether it is the final command of the item.
	assign xfer = pend_q && ob_free && (state_q != S_SCAN || hit);

	always_comb begin
		hit = 1'b0;
		case (job_q.kind)
			K_OFF: hit = used_q[iv] && sch_q[iv] == job_q.channel && snote_q[iv] == job_q.note;
			K_ALL: hit = job_q.all || (used_q[iv] && sch_q[iv] == job_q.channel);
			K_BEND: hit = used_q[iv] && sch_q[iv] == job_q.channel;
			default: hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) job_q <= job;
		if (xfer) begin
			command <= pcmd_q;
			voice <= 5'(pv_q);
			out_channel <= pch_q;
			out_note <= (pcmd_q == CMD_START) ? job_q.note : 7'd0;
			out_velocity <= (pcmd_q == CMD_START) ? job_q.velocity : 7'd0;
			out_program <= (pcmd_q == CMD_START) ? cprog_q[cidx] : 7'd0;
			out_bend <= pbend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			age_q <= '0;
			out_valid <= 1'b0;
			last <= 1'b0;
			pend_q <= 1'b0;
			idx_q <= '0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			best_q <= '0;
			oldest_q <= '0;
			pcmd_q <= '0;
			pv_q <= '0;
			pch_q <= '0;
			pbend_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				sch_q[i] <= '0;
				snote_q[i] <= '0;
				sstamp_q[i] <= '0;
			end
			for (int c = 0; c < CHANNELS; c++) begin
				cbend_q[c] <= '0;
				cprog_q[c] <= '0;
			end
		end else if (clear) begin
			used_q <= '0;
			age_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				sch_q[i] <= '0;
				snote_q[i] <= '0;
				sstamp_q[i] <= '0;
			end
			for (int c = 0; c < CHANNELS; c++) begin
				cbend_q[c] <= '0;
				cprog_q[c] <= '0;
			end
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (xfer) begin
				out_valid <= 1'b1;
				pend_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (job_valid) begin
					idx_q <= '0;
					found_q <= 1'b0;
					free_q <= 1'b0;
					if (job.kind == K_PROG) cprog_q[job.channel] <= job.program_value;
					else if (job.kind != K_NONE) state_q <= S_SCAN;
				end
				S_SCAN: if (!pend_q || !hit || ob_free) begin
					if (job_q.kind == K_NONE) state_q <= S_IDLE;
					if (job_q.kind == K_BEND && idx_q == '0) cbend_q[cidx] <= job_q.bend;
					if (job_q.kind == K_ON) begin
						if (!free_q) begin
							if (!used_q[iv]) begin
								free_q <= 1'b1;
								found_q <= 1'b1;
								best_q <= iv;
							end else if (!found_q || sstamp_q[iv] < oldest_q) begin
								found_q <= 1'b1;
								best_q <= iv;
								oldest_q <= sstamp_q[iv];
							end
						end
						if (at_end) state_q <= S_EMIT;
						else idx_q <= idx_q + 6'd1;
					end else begin
						if (hit) begin
							pend_q <= 1'b1;
							pv_q <= iv;
							pcmd_q <= (job_q.kind == K_BEND) ? CMD_RETUNE : CMD_STOP;
							pch_q <= (job_q.kind == K_BEND) ? job_q.channel :
								(used_q[iv] ? sch_q[iv] : 4'd0);
							pbend_q <= (job_q.kind == K_BEND) ? job_q.bend : 14'd0;
							found_q <= 1'b1;
							if (job_q.kind != K_BEND) used_q[iv] <= 1'b0;
							if (job_q.kind != K_BEND) begin
								sch_q[iv] <= '0;
								snote_q[iv] <= '0;
								sstamp_q[iv] <= '0;
							end
						end
						if (at_end) state_q <= S_WAIT;
						else idx_q <= idx_q + 6'd1;
					end
				end
				S_EMIT: if (!pend_q || ob_free) begin
					pend_q <= 1'b1;
					pv_q <= best_q;
					pcmd_q <= CMD_STOP;
					pch_q <= used_q[best_q] ? sch_q[best_q] : 4'd0;
					pbend_q <= 14'd0;
					used_q[best_q] <= 1'b1;
					sch_q[best_q] <= job_q.channel;
					snote_q[best_q] <= job_q.note;
					sstamp_q[best_q] <= age_q + 32'd1;
					age_q <= age_q + 32'd1;
					state_q <= S_START;
				end
				S_START: if (!pend_q || ob_free) begin
					pend_q <= 1'b1;
					pcmd_q <= CMD_START;
					pch_q <= job_q.channel;
					pbend_q <= cbend_q[cidx];
					state_q <= S_WAIT;
				end
				S_WAIT: if (!pend_q || ob_free) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (xfer)
				last <= (state_q == S_WAIT) || (state_q == S_START && pcmd_q == CMD_START);
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		job_ready |-> (state_q == S_IDLE)) else $error("ready outside idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

/* rtl/core/midi_voice_allocator.sv */
`default_nettype none
// MIDI voice allocator with oldest-voice stealing.
// Events enter on in_valid/in_ready with one field per port. A two-entry
// queue separates the classifier from the slot engine, so the input side
// can take events while the engine works.
// The engine scans slots one per cycle unless a match waits on a stalled
// output. A note-on scans, then steps through emit, start and wait; other
// scans go on to wait. Program changes and ignored events skip the scan.
// Results leave through a registered output on out_valid/out_ready; "last"
// marks the final command of an event. A stop or retune found in a scan is
// held until the next match or the end of the scan. A stalled receiver holds
// the output register and the scan waits on it, so nothing is lost.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data:
// index 0 sets active_chips (clamped), index 1 sets bank_ready. A change of
// chip count clears all voice and channel state.
// Reset clears all voices, bends, programs and the age counter, selects
// one chip and marks the bank not ready.
module midi_voice_allocator (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_ready,
	input wire [2:0] operation,
	input wire [3:0] channel,
	input wire all_channels,
	input wire [6:0] note,
	input wire [6:0] velocity,
	input wire signed [13:0] bend,
	input wire [6:0] program_value,
	input wire cfg_valid,
	output logic cfg_ready,
	input wire cfg_index,
	input wire [2:0] cfg_data,
	output logic out_valid,
	input wire out_ready,
	output logic [1:0] command,
	output logic [4:0] voice,
	output logic [3:0] out_channel,
	output logic [6:0] out_note,
	output logic [6:0] out_velocity,
	output logic [6:0] out_program,
	output logic signed [13:0] out_bend,
	output logic last
);
	import mva_pkg::*;
	logic [2:0] chips_q;
	logic bank_q, clear;
	logic [2:0] want;
	logic job_valid, job_ready;
	job_t job;
	logic [5:0] capacity;
	logic [13:0] ob;

	assign cfg_ready = 1'b1;
	always_comb begin
		want = cfg_data;
		if (want == 3'd0) want = 3'd1;
		if ({1'b0, want} > 4'(MAX_CHIPS)) want = 3'(MAX_CHIPS);
	end
	assign clear = cfg_valid && cfg_index == CFG_ACTIVE_CHIPS && want != chips_q;
	assign capacity = 6'(int'(chips_q) * VOICES_PER_CHIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chips_q <= 3'd1;
			bank_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_ACTIVE_CHIPS) chips_q <= want;
			else bank_q <= cfg_data[0];
		end
	end

	mva_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .operation, .channel, .all_channels,
		.note, .velocity, .bend(bend), .program_value, .bank_ready(bank_q),
		.job_valid, .job_ready, .job
	);

	mva_back u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job, .capacity, .clear,
		.out_valid, .out_ready, .command, .voice, .out_channel, .out_note,
		.out_velocity, .out_program, .out_bend(ob), .last
	);
	assign out_bend = ob;
endmodule
`default_nettype wire

/* dv/tb_midi_voice_allocator.sv */
`default_nettype none
module tb_midi_voice_allocator;
	import mva_pkg::*;

	localparam int NUM_SLOTS = 32;
	localparam int NUM_CH = 16;
	localparam int QUIET_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLDOFF_CYCLES = 400;

	typedef struct {
		bit is_cfg;
		logic cfg_idx;
		logic [2:0] cfg_val;
		logic [2:0] op;
		logic [3:0] ch;
		logic all;
		logic [6:0] note;
		logic [6:0] vel;
		logic [13:0] bend;
		logic [6:0] prog;
	} event_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [4:0] voice;
		logic [3:0] ch;
		logic [6:0] note;
		logic [6:0] vel;
		logic [6:0] prog;
		logic [13:0] bend;
		logic last;
	} voice_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] operation = '0;
	logic [3:0] channel = '0;
	logic all_channels = 1'b0;
	logic [6:0] note = '0;
	logic [6:0] velocity = '0;
	logic [13:0] bend = '0;
	logic [6:0] program_value = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [2:0] cfg_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] command;
	logic [4:0] voice;
	logic [3:0] out_channel;
	logic [6:0] out_note;
	logic [6:0] out_velocity;
	logic [6:0] out_program;
	logic [13:0] out_bend;
	logic last;

	midi_voice_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .channel(channel), .all_channels(all_channels),
		.note(note), .velocity(velocity), .bend(bend), .program_value(program_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.command(command), .voice(voice), .out_channel(out_channel),
		.out_note(out_note), .out_velocity(out_velocity), .out_program(out_program),
		.out_bend(out_bend), .last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Voice table mirror.
	bit slot_on[NUM_SLOTS];
	logic [3:0] slot_ch[NUM_SLOTS];
	logic [6:0] slot_nt[NUM_SLOTS];
	logic [31:0] slot_age[NUM_SLOTS];
	logic [31:0] age_ctr;
	logic [13:0] ch_bend[NUM_CH];
	logic [6:0] ch_prog[NUM_CH];
	int chips;
	bit bank_on;

	event_t pending[$];
	voice_cmd_t expected_cmds[$];
	voice_cmd_t burst[$];
	int errors = 0;
	int events_sent = 0;
	int cfg_writes = 0;
	int cmds_seen = 0;
	int steals = 0;

	task automatic report(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	function automatic void clear_voices();
		for (int v = 0; v < NUM_SLOTS; v++) begin
			slot_on[v] = 0;
			slot_ch[v] = '0;
			slot_nt[v] = '0;
			slot_age[v] = '0;
		end
		for (int c = 0; c < NUM_CH; c++) begin
			ch_bend[c] = '0;
			ch_prog[c] = '0;
		end
		age_ctr = '0;
	endfunction

	function automatic void push_cmd(cmd_t c, int v, logic [3:0] ch, logic [6:0] nt,
			logic [6:0] vl, logic [6:0] pg, logic [13:0] bd);
		voice_cmd_t r;
		r.cmd = c;
		r.voice = v[4:0];
		r.ch = ch;
		r.note = nt;
		r.vel = vl;
		r.prog = pg;
		r.bend = bd;
		r.last = 1'b0;
		burst.push_back(r);
	endfunction

	function automatic void silence_slot(int v);
		push_cmd(CMD_STOP, v, slot_on[v] ? slot_ch[v] : 4'd0, '0, '0, '0, '0);
		slot_on[v] = 0;
		slot_ch[v] = '0;
		slot_nt[v] = '0;
		slot_age[v] = '0;
	endfunction

	function automatic void apply_config(logic idx, logic [2:0] val);
		int want;
		if (idx == CFG_ACTIVE_CHIPS) begin
			want = val;
			if (want < 1) want = 1;
			if (want > 4) want = 4;
			if (want != chips) begin
				chips = want;
				clear_voices();
			end
		end else begin
			bank_on = val[0];
		end
	endfunction

	function automatic void predict_commands(event_t e);
		int cap;
		int pick;
		logic [31:0] oldest;
		cap = chips * 8;
		if (cap > NUM_SLOTS) cap = NUM_SLOTS;
		burst.delete();
		pick = -1;
		oldest = '0;
		case (e.op)
			OP_NOTE_ON, OP_NOTE_OFF: begin
				if (e.op == OP_NOTE_ON && !bank_on) begin
				end else if (e.op == OP_NOTE_OFF || e.vel == 0) begin
					for (int v = 0; v < cap; v++)
						if (slot_on[v] && slot_ch[v] == e.ch && slot_nt[v] == e.note)
							silence_slot(v);
				end else begin
					for (int v = 0; v < cap && pick < 0; v++)
						if (!slot_on[v]) pick = v;
					if (pick < 0) begin
						steals++;
						for (int v = 0; v < cap; v++)
							if (slot_on[v] && (pick < 0 || slot_age[v] < oldest)) begin
								pick = v;
								oldest = slot_age[v];
							end
					end
					silence_slot(pick);
					age_ctr = age_ctr + 1;
					slot_on[pick] = 1;
					slot_ch[pick] = e.ch;
					slot_nt[pick] = e.note;
					slot_age[pick] = age_ctr;
					push_cmd(CMD_START, pick, e.ch, e.note, e.vel, ch_prog[e.ch],
						ch_bend[e.ch]);
				end
			end
			OP_ALL_OFF: begin
				for (int v = 0; v < cap; v++)
					if (e.all || (slot_on[v] && slot_ch[v] == e.ch)) silence_slot(v);
			end
			OP_BEND: begin
				ch_bend[e.ch] = e.bend;
				for (int v = 0; v < cap; v++)
					if (slot_on[v] && slot_ch[v] == e.ch)
						push_cmd(CMD_RETUNE, v, e.ch, '0, '0, '0, e.bend);
			end
			OP_PROGRAM: ch_prog[e.ch] = e.prog;
			default: ;
		endcase
		if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i]) expected_cmds.push_back(burst[i]);
	endfunction

	task automatic add_event(logic [2:0] op, logic [3:0] ch, logic all, logic [6:0] nt,
			logic [6:0] vl, logic [13:0] bd, logic [6:0] pg);
		event_t e;
		e.is_cfg = 0;
		e.cfg_idx = 1'b0;
		e.cfg_val = '0;
		e.op = op;
		e.ch = ch;
		e.all = all;
		e.note = nt;
		e.vel = vl;
		e.bend = bd;
		e.prog = pg;
		pending.push_back(e);
	endtask

	task automatic add_config(logic idx, logic [2:0] val);
		event_t e;
		e = '{default: '0};
		e.is_cfg = 1;
		e.cfg_idx = idx;
		e.cfg_val = val;
		pending.push_back(e);
	endtask

	// Mostly notes from a small pool on a few channels so that note-offs and retunes
	// find sounding voices; other kinds share those channels, the rest is full-range noise.
	task automatic add_random_event();
		int r;
		logic [3:0] ch;
		logic [6:0] nt;
		logic ra;
		logic [3:0] rc;
		logic [6:0] rn;
		logic [6:0] rv;
		logic [6:0] rp;
		logic [13:0] rb;
		r = $urandom_range(0, 99);
		ch = 4'($urandom_range(0, 3));
		nt = 7'(60 + $urandom_range(0, 7));
		ra = 1'($urandom);
		rc = 4'($urandom);
		rn = 7'($urandom);
		rv = 7'($urandom);
		rp = 7'($urandom);
		rb = 14'($urandom);
		if (r < 45)
			add_event(OP_NOTE_ON, ch, ra, nt,
				($urandom_range(0, 19) == 0) ? 7'd0 : 7'($urandom_range(1, 127)), rb, rp);
		else if (r < 65)
			add_event(OP_NOTE_OFF, ch, ra, nt, rv, rb, rp);
		else if (r < 72)
			add_event(OP_ALL_OFF, ch, ($urandom_range(0, 3) == 0), rn, rv, rb, rp);
		else if (r < 82)
			add_event(OP_BEND, ch, ra, rn, rv, rb, rp);
		else if (r < 90)
			add_event(OP_PROGRAM, ch, ra, rn, rv, rb, rp);
		else if (r < 93)
			add_event(3'($urandom_range(5, 7)), rc, ra, rn, rv, rb, rp);
		else
			add_event(3'($urandom_range(0, 4)), rc, ra, rn, rv, rb, rp);
	endtask

	// Driver.
	int gap = 0;
	int quiet = 0;
	int burst_left = 0;
	always @(posedge clk or negedge arst_n) begin
		logic nv;
		logic ncv;
		event_t e;
		int r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
			gap = 0;
			quiet = 0;
		end else begin
			nv = in_valid;
			ncv = cfg_valid;
			if (expected_cmds.size() == 0 && !in_valid && !out_valid) quiet++;
			else quiet = 0;
			if (in_valid && in_ready) begin
				predict_commands('{0, 1'b0, 3'd0, operation, channel, all_channels, note,
					velocity, bend, program_value});
				events_sent++;
				nv = 1'b0;
				if (burst_left > 0) begin
					burst_left--;
					gap = 0;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 3) burst_left = $urandom_range(10, 30);
					if (r < 50) gap = 0;
					else if (r < 90) gap = $urandom_range(1, 3);
					else gap = $urandom_range(10, 60);
				end
			end
			if (cfg_valid && cfg_ready) begin
				apply_config(cfg_index, cfg_data);
				cfg_writes++;
				ncv = 1'b0;
			end
			if (gap > 0) begin
				gap--;
			end else if (!nv && !ncv && pending.size() > 0) begin
				e = pending[0];
				if (!e.is_cfg) begin
					void'(pending.pop_front());
					operation <= e.op;
					channel <= e.ch;
					all_channels <= e.all;
					note <= e.note;
					velocity <= e.vel;
					bend <= e.bend;
					program_value <= e.prog;
					nv = 1'b1;
				end else if (quiet >= QUIET_CYCLES) begin
					void'(pending.pop_front());
					cfg_index <= e.cfg_idx;
					cfg_data <= e.cfg_val;
					ncv = 1'b1;
				end
			end
			in_valid <= nv;
			cfg_valid <= ncv;
		end
	end

	// Monitor and receiver.
	int hold = 0;
	bit held_off = 0;
	always @(posedge clk or negedge arst_n) begin
		voice_cmd_t got;
		voice_cmd_t want;
		logic rdy;
		int r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{command, voice, out_channel, out_note, out_velocity, out_program,
					out_bend, last};
				cmds_seen++;
				if (expected_cmds.size() == 0) begin
					report($sformatf("unexpected command %0d voice %0d", command, voice));
				end else begin
					want = expected_cmds.pop_front();
					if (got !== want)
						report($sformatf({"cmd %0d/%0d voice %0d/%0d ch %0d/%0d note %0d/%0d ",
							"vel %0d/%0d prog %0d/%0d bend %0d/%0d last %0d/%0d (got/want)"},
							got.cmd, want.cmd, got.voice, want.voice, got.ch, want.ch,
							got.note, want.note, got.vel, want.vel, got.prog, want.prog,
							got.bend, want.bend, got.last, want.last));
				end
			end
			if (hold > 0) begin
				hold--;
				rdy = 1'b0;
			end else if (!held_off && cmds_seen >= 60) begin
				held_off = 1;
				hold = HOLDOFF_CYCLES;
				rdy = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				rdy = 1'b1;
				if (r < 25) rdy = 1'b0;
				if (r < 3) hold = $urandom_range(10, 50);
			end
			out_ready <= rdy;
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL midi_voice_allocator");
			$finish;
		end
	end

	initial begin
		chips = 1;
		bank_on = 0;
		clear_voices();

		add_event(OP_NOTE_ON, 4'd1, 1'b0, 7'd60, 7'd100, '0, '0);
		add_config(CFG_BANK_READY, 3'd1);
		add_config(CFG_ACTIVE_CHIPS, 3'd1);
		add_event(OP_PROGRAM, 4'd15, 1'b0, '0, '0, '0, 7'd127);
		add_event(OP_BEND, 4'd15, 1'b0, '0, '0, 14'h2000, '0);
		add_event(OP_NOTE_ON, 4'd15, 1'b0, 7'd127, 7'd127, '0, '0);
		add_event(OP_NOTE_ON, 4'd15, 1'b0, 7'd127, 7'd0, '0, '0);
		for (int i = 0; i < 9; i++)
			add_event(OP_NOTE_ON, i[3:0] & 4'd3, 1'b0, 7'(40 + i), 7'(1 + i), '0, '0);
		add_event(OP_NOTE_OFF, 4'd1, 1'b0, 7'd41, '0, '0, '0);
		add_event(OP_NOTE_OFF, 4'd9, 1'b0, 7'd0, '0, '0, '0);
		add_event(OP_BEND, 4'd2, 1'b0, '0, '0, 14'h1fff, '0);
		add_event(OP_ALL_OFF, 4'd3, 1'b0, '0, '0, '0, '0);
		add_event(OP_ALL_OFF, 4'd0, 1'b1, '0, '0, '0, '0);
		add_event(3'd5, 4'd0, 1'b1, 7'd1, 7'd1, '0, '0);
		add_event(3'd6, 4'd15, 1'b0, 7'd127, 7'd127, 14'h3fff, 7'd127);
		add_event(3'd7, 4'd1, 1'b0, '0, '0, '0, '0);
		add_config(CFG_BANK_READY, 3'd0);
		add_event(OP_NOTE_ON, 4'd0, 1'b0, 7'd60, 7'd0, '0, '0);
		add_config(CFG_BANK_READY, 3'd1);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: add_config(CFG_ACTIVE_CHIPS, 3'd7);
				1: add_config(CFG_ACTIVE_CHIPS, 3'd0);
				2: add_config(CFG_ACTIVE_CHIPS, 3'd2);
				default: add_config(CFG_ACTIVE_CHIPS, 3'd4);
			endcase
			add_config(CFG_BANK_READY, (p == 3) ? 3'd6 : 3'd1);
			for (int i = 0; i < 50; i++) add_random_event();
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (pending.size() > 0 || in_valid || cfg_valid || expected_cmds.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Ran %0d events and %0d register writes; checked %0d voice commands.",
			events_sent, cfg_writes, cmds_seen);
		$display("Chip counts 1 to 4 with clamping, %0d steals, one long output stall.",
			steals);
		if (errors == 0 && expected_cmds.size() == 0) begin
			$display("PASS midi_voice_allocator");
		end else begin
			$display("FAIL midi_voice_allocator");
		end
		$finish;
	end
endmodule
`default_nettype wire
